>>> src/fdvp_pkg.sv
package fdvp_pkg;

  // Frame storage depth; a frame holds at most BufferBytes-1 payload bytes
  localparam int BufferBytes = 6;
  localparam int CountW      = $clog2(BufferBytes);
  localparam logic [CountW-1:0] MaxPayload = CountW'(BufferBytes - 1);

  localparam int ByteW  = 8;
  localparam int ValueW = 16;

  // Framing and character codes
  localparam logic [ByteW-1:0] StartMark = 8'h40;  // '@'
  localparam logic [ByteW-1:0] EndMark   = 8'h25;  // '%'
  localparam logic [ByteW-1:0] MinusMark = 8'h2D;  // '-'
  localparam logic [ByteW-1:0] DigitZero = 8'h30;  // '0'
  localparam logic [ByteW-1:0] NulByte   = 8'h00;

  // Result of one item leaving the parse stage
  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
  } fdvp_res_t;

endpackage

>>> src/fdvp_step.sv
module fdvp_step import fdvp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [ByteW-1:0] rx_byte_i,
  output fdvp_res_t        res_o
);

  logic              in_frame_q, in_frame_d;
  logic [CountW-1:0] count_q, count_d;
  logic              negate_q, negate_d;
  logic              stopped_q, stopped_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [ValueW-1:0] acc_times10;
  logic [ValueW-1:0] acc_next;

  // acc*10 + byte - '0', wrapping
  assign acc_times10 = {acc_q[ValueW-4:0], 3'b000} + {acc_q[ValueW-2:0], 1'b0};
  assign acc_next    = acc_times10 + ValueW'(rx_byte_i) - ValueW'(DigitZero);

  // Frame state update for one item
  always_comb begin
    in_frame_d  = in_frame_q;
    count_d     = count_q;
    negate_d    = negate_q;
    stopped_d   = stopped_q;
    acc_d       = acc_q;
    res_o.valid = 1'b0;
    res_o.value = negate_q ? $signed(-acc_q) : $signed(acc_q);
    if (fire_i) begin
      if (!in_frame_q) begin
        if (rx_byte_i == StartMark) begin
          in_frame_d = 1'b1;
          count_d    = '0;
          negate_d   = 1'b0;
          stopped_d  = 1'b0;
          acc_d      = '0;
        end
      end else if (rx_byte_i == EndMark) begin
        res_o.valid = 1'b1;
        in_frame_d  = 1'b0;
      end else if (count_q >= MaxPayload) begin
        // overlong frame: drop silently
        in_frame_d = 1'b0;
      end else begin
        if (!stopped_q) begin
          if (rx_byte_i == NulByte) begin
            stopped_d = 1'b1;
          end else if (count_q == '0 && rx_byte_i == MinusMark) begin
            negate_d = 1'b1;
          end else begin
            acc_d = acc_next;
          end
        end
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
      negate_q   <= 1'b0;
      stopped_q  <= 1'b0;
      acc_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      negate_q   <= negate_d;
      stopped_q  <= stopped_d;
      acc_q      <= acc_d;
    end
  end

  // A result only closes an open frame
  a_res_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> in_frame_q)
    else $error("result produced outside a frame");

  // Payload count stays within the frame limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxPayload)
    else $error("payload count beyond limit");

  // Negation is only taken from the first payload byte
  a_negate_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(negate_q) |-> count_q == CountW'(1))
    else $error("negate set after first payload byte");

endmodule

>>> src/fdvp_out_reg.sv
module fdvp_out_reg import fdvp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fdvp_res_t                res_i,
  input  logic                     out_stall_i,
  output logic                     ready_o,
  output logic                     out_valid_o,
  output logic signed [ValueW-1:0] value_o
);

  logic                     valid_q, valid_d;
  logic signed [ValueW-1:0] value_q, value_d;

  // Slot free when empty or being taken this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ready_o) begin
      valid_d = res_i.valid;
      if (res_i.valid) begin
        value_d = res_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign out_valid_o = valid_q;
  assign value_o     = value_q;

endmodule

>>> src/framed_decimal_value_parser_unit.sv
// Channel | Valid       | Stall       | Payload
// --------+-------------+-------------+--------------------------
// input   | in_valid_i  | in_stall_o  | rx_byte_i [7:0]
// output  | out_valid_o | out_stall_i | value_o   [15:0] signed
//
// One byte per clock when the output is not stalled.
// The closing '%' passes the input register, then the parse stage into the result
// register, from which value_o shows the value once out_valid_o is set.
// Asynchronous active-low reset clears the frame state and empties both stages.
// A stalled output holds the result; the input stalls only while a held byte
// could not move on into a full result register.
module framed_decimal_value_parser_unit import fdvp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ByteW-1:0]         rx_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ValueW-1:0] value_o
);

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] rx_byte_q;
  logic             out_ready;
  logic             fire;
  logic             load;
  fdvp_res_t        res;

  // Input register handshake
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rx_byte_q <= rx_byte_i;
    end
  end

  fdvp_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .rx_byte_i (rx_byte_q),
    .res_o     (res)
  );

  fdvp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .value_o     (value_o)
  );

endmodule

>>> tb/sv/framed_decimal_value_parser_unit_tb.sv
module framed_decimal_value_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fdvp_pkg::*;

  localparam int MaxHeld       = int'(MaxPayload);
  localparam int RandomItems   = 500;
  localparam int DrainCycles   = 8;
  localparam int WatchdogLimit = 1000;
  localparam logic [ValueW-1:0] Radix = ValueW'(10);

  // Directed rows: byte, and a typed-in value where it is obvious
  typedef struct packed {
    logic [ByteW-1:0]  rx;
    logic              pinned;
    logic [ValueW-1:0] pval;
  } dir_row_t;

  localparam int DirN = 27;
  localparam dir_row_t DirRows [DirN] = '{
    // empty payload
    '{StartMark, 1'b0, 16'h0000},
    '{EndMark,   1'b1, 16'h0000},
    // largest magnitude, wraps past 2^16
    '{StartMark, 1'b0, 16'h0000},
    '{8'h39,     1'b0, 16'h0000},
    '{8'h39,     1'b0, 16'h0000},
    '{8'h39,     1'b0, 16'h0000},
    '{8'h39,     1'b0, 16'h0000},
    '{8'h39,     1'b0, 16'h0000},
    '{EndMark,   1'b1, -16'sd31073},
    // leading minus
    '{StartMark, 1'b0, 16'h0000},
    '{MinusMark, 1'b0, 16'h0000},
    '{8'h31,     1'b0, 16'h0000},
    '{EndMark,   1'b1, -16'sd1},
    // non-digit, minus not first, zero byte stops, later byte ignored
    '{StartMark, 1'b0, 16'h0000},
    '{8'hFF,     1'b0, 16'h0000},
    '{MinusMark, 1'b0, 16'h0000},
    '{NulByte,   1'b0, 16'h0000},
    '{8'h37,     1'b0, 16'h0000},
    '{EndMark,   1'b0, 16'h0000},
    // start mark as payload, then one byte too many drops the frame
    '{StartMark, 1'b0, 16'h0000},
    '{StartMark, 1'b0, 16'h0000},
    '{8'h31,     1'b0, 16'h0000},
    '{8'h32,     1'b0, 16'h0000},
    '{8'h33,     1'b0, 16'h0000},
    '{8'h34,     1'b0, 16'h0000},
    '{8'h35,     1'b0, 16'h0000},
    // end mark while idle is ignored
    '{EndMark,   1'b0, 16'h0000}
  };

  typedef struct {
    logic [ByteW-1:0]         rx;
    int unsigned              gap;
    bit                       pinned;
    logic signed [ValueW-1:0] pval;
  } stim_item_t;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [ByteW-1:0]         rx_byte_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [ValueW-1:0] value_o;

  // travel with the driven byte so the scoreboard sees them at acceptance
  logic                     cur_pinned = 1'b0;
  logic signed [ValueW-1:0] cur_pinned_value = '0;

  stim_item_t               byte_plan [$];
  logic signed [ValueW-1:0] expected_values [$];
  int unsigned              fails = 0;
  int unsigned              idle_cycles = 0;

  // parser state as predicted
  bit                       frame_open = 1'b0;
  logic [CountW-1:0]        held_cnt = '0;
  bit                       neg_pending = 1'b0;
  bit                       acc_stopped = 1'b0;
  logic [ValueW-1:0]        acc_q = '0;

  framed_decimal_value_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one byte into the frame parser; emit is set when a value comes out
  task automatic predict_byte(input logic [ByteW-1:0] b, output bit emit,
                              output logic signed [ValueW-1:0] v);
    emit = 1'b0;
    v    = '0;
    if (!frame_open) begin
      if (b == StartMark) begin
        frame_open  = 1'b1;
        held_cnt    = '0;
        neg_pending = 1'b0;
        acc_stopped = 1'b0;
        acc_q       = '0;
      end
    end else if (b == EndMark) begin
      v          = neg_pending ? -acc_q : acc_q;
      emit       = 1'b1;
      frame_open = 1'b0;
    end else if (held_cnt >= MaxPayload) begin
      // one payload byte too many: frame dropped
      frame_open = 1'b0;
    end else begin
      if (!acc_stopped) begin
        if (b == NulByte) begin
          acc_stopped = 1'b1;
        end else if (held_cnt == '0 && b == MinusMark) begin
          neg_pending = 1'b1;
        end else begin
          acc_q = acc_q * Radix + ValueW'(b) - ValueW'(DigitZero);
        end
      end
      held_cnt = held_cnt + 1'b1;
    end
  endtask

  // predict on accepted bytes, check accepted values
  always @(posedge clk_i) begin
    bit                       emit;
    logic signed [ValueW-1:0] v;
    logic signed [ValueW-1:0] want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_byte(rx_byte_i, emit, v);
        if (emit) expected_values.push_back(cur_pinned ? cur_pinned_value : v);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_values.size() == 0) begin
          $error("value_o: no value expected, got %0d", value_o);
          fails++;
        end else begin
          want = expected_values.pop_front();
          if (value_o !== want) begin
            $error("value_o: expected %0d, got %0d", want, value_o);
            fails++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WatchdogLimit) begin
        $display("framed_decimal_value_parser_unit_tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // output back-pressure: free and stalled stretches of random length
  initial begin
    int unsigned r;
    int unsigned len;
    bit          hold;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        hold = 1'b0;
        len  = $urandom_range(1, 20);
      end else if (r < 70) begin
        hold = 1'b0;
        len  = $urandom_range(50, 150);
      end else if (r < 95) begin
        hold = 1'b1;
        len  = $urandom_range(1, 4);
      end else begin
        hold = 1'b1;
        len  = $urandom_range(20, 60);
      end
      out_stall_i <= hold;
      repeat (len) @(posedge clk_i);
    end
  end

  initial begin
    stim_item_t       it;
    int unsigned      counted;
    int unsigned      n;
    int unsigned      r;
    int unsigned      k;
    bit               quiet;
    logic [ByteW-1:0] b;

    // directed table
    foreach (DirRows[i]) begin
      it.rx     = DirRows[i].rx;
      it.gap    = gap_len();
      it.pinned = DirRows[i].pinned;
      it.pval   = DirRows[i].pval;
      byte_plan.push_back(it);
    end

    // random frames, mostly well formed, some overlong or unterminated
    it.pinned = 1'b0;
    it.pval   = '0;
    counted   = 0;
    while (counted < RandomItems) begin
      quiet = ($urandom_range(0, 3) == 0);
      // stray bytes between frames
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          b = ByteW'($urandom);
          if (b == StartMark) b = EndMark;
          it.rx  = b;
          it.gap = quiet ? 0 : gap_len();
          byte_plan.push_back(it);
        end
      end
      it.rx  = StartMark;
      it.gap = quiet ? 0 : gap_len();
      byte_plan.push_back(it);
      counted++;
      r = $urandom_range(0, 99);
      n = (r < 8) ? MaxHeld + 1 : $urandom_range(0, MaxHeld);
      for (k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (k == 0 && r < 25) b = MinusMark;
        else if (r < 70)      b = DigitZero + ByteW'($urandom_range(0, 9));
        else if (r < 76)      b = NulByte;
        else if (r < 80)      b = StartMark;
        else                  b = ByteW'($urandom);
        it.rx  = b;
        it.gap = quiet ? 0 : gap_len();
        byte_plan.push_back(it);
        counted++;
      end
      if ((n <= MaxHeld) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 1) == 0)) begin
        it.rx  = EndMark;
        it.gap = quiet ? 0 : gap_len();
        byte_plan.push_back(it);
        counted++;
      end
    end

    // reset
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drive the planned bytes
    foreach (byte_plan[i]) begin
      if (byte_plan[i].gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (byte_plan[i].gap) @(posedge clk_i);
      end
      in_valid_i       <= 1'b1;
      rx_byte_i        <= byte_plan[i].rx;
      cur_pinned       <= byte_plan[i].pinned;
      cur_pinned_value <= byte_plan[i].pval;
      do @(posedge clk_i); while (in_stall_o);
    end
    in_valid_i <= 1'b0;

    // drain once the last accepted byte has been predicted
    @(posedge clk_i);
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fails == 0) begin
      $display("framed_decimal_value_parser_unit_tb passed");
    end else begin
      $display("framed_decimal_value_parser_unit_tb failed");
    end
    $finish;
  end

endmodule
